// ----- hw/rtl/xlsu_pkg.sv -----
// Shared opcodes, size codes and payload types for the logic and shift unit.
package xlsu_pkg;

    localparam logic [3:0] OP_AND  = 4'd0;
    localparam logic [3:0] OP_OR   = 4'd1;
    localparam logic [3:0] OP_XOR  = 4'd2;
    localparam logic [3:0] OP_TEST = 4'd3;
    localparam logic [3:0] OP_NOT  = 4'd4;
    localparam logic [3:0] OP_SAR  = 4'd5;
    localparam logic [3:0] OP_SHL  = 4'd6;
    localparam logic [3:0] OP_SHR  = 4'd7;
    localparam logic [3:0] OP_ROL  = 4'd8;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  size_code;
        logic [31:0] dest_value;
        logic [31:0] src_value;
    } t_op_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_back;
        logic        zero_flag;
        logic        sign_flag;
        logic        zf_sf_update;
        logic        clear_carry_overflow;
    } t_result;

endpackage

// ----- hw/rtl/xlsu_if.sv -----
// Valid/ready channel interfaces for instruction input and result output.
interface xlsu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [1:0]  size_code;
    logic [31:0] dest_value;
    logic [31:0] src_value;

    modport source (output valid, output op, output size_code, output dest_value,
                    output src_value, input ready);
    modport sink   (input valid, input op, input size_code, input dest_value,
                    input src_value, output ready);
endinterface

interface xlsu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        write_back;
    logic        zero_flag;
    logic        sign_flag;
    logic        zf_sf_update;
    logic        clear_carry_overflow;

    modport source (output valid, output result_value, output write_back,
                    output zero_flag, output sign_flag, output zf_sf_update,
                    output clear_carry_overflow, input ready);
    modport sink   (input valid, input result_value, input write_back,
                    input zero_flag, input sign_flag, input zf_sf_update,
                    input clear_carry_overflow, output ready);
endinterface

// ----- hw/rtl/xlsu_alu.sv -----
// Combinational logic, shift and rotate datapath with flag generation.
module xlsu_alu
    import xlsu_pkg::*;
(
    input  t_op_item i_item,
    output t_result  o_result
);

    always_comb begin
        logic [31:0] mask;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] sext;
        logic [31:0] rep;
        logic [63:0] rot;
        logic [4:0]  cnt;
        logic [31:0] r;
        logic        sbit;
        logic        wb;
        logic        upd;
        logic        clr;

        cnt = i_item.src_value[4:0];
        case (i_item.size_code)
            SIZE_8: begin
                mask = 32'h0000_00FF;
            end
            SIZE_16: begin
                mask = 32'h0000_FFFF;
            end
            default: begin
                mask = 32'hFFFF_FFFF;
            end
        endcase
        d = i_item.dest_value & mask;
        s = i_item.src_value & mask;
        case (i_item.size_code)
            SIZE_8: begin
                sext = {{24{d[7]}}, d[7:0]};
                rep  = {4{d[7:0]}};
            end
            SIZE_16: begin
                sext = {{16{d[15]}}, d[15:0]};
                rep  = {2{d[15:0]}};
            end
            default: begin
                sext = d;
                rep  = d;
            end
        endcase
        rot = {rep, rep} << cnt;

        r   = d;
        wb  = 1'b1;
        upd = 1'b1;
        clr = 1'b0;
        unique case (i_item.op)
            OP_AND: begin
                r   = d & s;
                clr = 1'b1;
            end
            OP_OR: begin
                r   = d | s;
                clr = 1'b1;
            end
            OP_XOR: begin
                r   = d ^ s;
                clr = 1'b1;
            end
            OP_TEST: begin
                r   = d & s;
                clr = 1'b1;
                wb  = 1'b0;
            end
            OP_NOT: begin
                r   = ~d;
                upd = 1'b0;
            end
            OP_SAR: begin
                r = $signed(sext) >>> cnt;
            end
            OP_SHL: begin
                r = d << cnt;
            end
            OP_SHR: begin
                r = d >> cnt;
            end
            OP_ROL: begin
                r = rot[63:32];
            end
            default: begin
                wb  = 1'b0;
                upd = 1'b0;
            end
        endcase
        r = r & mask;

        case (i_item.size_code)
            SIZE_8: begin
                sbit = r[7];
            end
            SIZE_16: begin
                sbit = r[15];
            end
            default: begin
                sbit = r[31];
            end
        endcase

        o_result.result_value         = r;
        o_result.write_back           = wb;
        o_result.zero_flag            = upd && (r == 32'd0);
        o_result.sign_flag            = upd && sbit;
        o_result.zf_sf_update         = upd;
        o_result.clear_carry_overflow = clr;
    end

endmodule

// ----- hw/rtl/x86_logic_shift_unit.sv -----
// An input register feeds the ALU, whose output lands in a result register.
// Throughput: one instruction per cycle unless the output stalls; each stage holds
// while the next one is full.
// Reset (i_rst_n low, synchronous) clears both stage valid bits; payloads are not reset.
// Top level of the logic and shift unit: input and result pipeline registers.
module x86_logic_shift_unit
    import xlsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    xlsu_in_if.sink           i_item,
    xlsu_out_if.source        o_item
);

    logic     r_in_valid;
    t_op_item r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_result  alu_result;
    logic     out_free;
    logic     in_take;

    assign out_free     = !r_out_valid || o_item.ready;
    assign i_item.ready = !r_in_valid || out_free;
    assign in_take      = i_item.valid && i_item.ready;

    xlsu_alu u_alu (
        .i_item   (r_in),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op         <= i_item.op;
            r_in.size_code  <= i_item.size_code;
            r_in.dest_value <= i_item.dest_value;
            r_in.src_value  <= i_item.src_value;
        end
        if (out_free && r_in_valid) begin
            r_out <= alu_result;
        end
    end

    assign o_item.valid                = r_out_valid;
    assign o_item.result_value         = r_out.result_value;
    assign o_item.write_back           = r_out.write_back;
    assign o_item.zero_flag            = r_out.zero_flag;
    assign o_item.sign_flag            = r_out.sign_flag;
    assign o_item.zf_sf_update         = r_out.zf_sf_update;
    assign o_item.clear_carry_overflow = r_out.clear_carry_overflow;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> r_out_valid)
        else $error("input stage advanced but result stage empty");

    a_no_update_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.zf_sf_update) |-> (!r_out.zero_flag && !r_out.sign_flag))
        else $error("flags set without update");

    a_clear_implies_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clear_carry_overflow) |-> r_out.zf_sf_update)
        else $error("carry/overflow clear without zf/sf update");

    a_byte_result_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.size_code == SIZE_8) |-> (alu_result.result_value[31:8] == 24'd0))
        else $error("byte result has upper bits set");
`endif

endmodule
